@@ rtl/core/cct_pkg.sv @@
// Cluster chain table: shared types, codes and the sequencer microprogram.
package cct_pkg;

    localparam int OP_W  = 2;
    localparam int CL_W  = 16;
    localparam int LEN_W = 24;
    localparam int EV_W  = 16;
    localparam int ST_W  = 2;
    localparam int CC_W  = 11;
    localparam int CS_W  = 16;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CL_W-1:0] FIND_FREE    = 16'hFFFF;
    localparam logic [7:0]      PARTIAL_MARK = 8'hFF;

    typedef logic [CFG_AW-3:0] t_reg_idx;
    localparam t_reg_idx REG_CLUSTER_COUNT = 1'b0;
    localparam t_reg_idx REG_CLUSTER_SIZE  = 1'b1;

    localparam logic [CC_W-1:0] CLUSTER_COUNT_RST = 11'd1024;
    localparam logic [CS_W-1:0] CLUSTER_SIZE_RST  = 16'd512;

    typedef logic [4:0] t_upc;

    typedef enum logic [1:0] {SQ_NEXT, SQ_JUMP, SQ_WAIT, SQ_DONE} t_seq;

    typedef enum logic [3:0] {
        CD_ALWAYS, CD_CLR_DONE, CD_CL_RANGE, CD_CL_FIND, CD_RD_ZERO,
        CD_RD_STOP, CD_RD_RANGE, CD_CUR_END, CD_LEN_LT
    } t_cond;

    typedef enum logic [1:0] {RS_NONE, RS_WP, RS_CUR} t_rsel;

    typedef enum logic [2:0] {
        WS_NONE, WS_CLR, WS_ZERO, WS_VAL, WS_PART, WS_END, WS_CUR
    } t_wsel;

    typedef enum logic [1:0] {WP_HOLD, WP_RD, WP_CUR} t_wpop;
    typedef enum logic [1:0] {CU_HOLD, CU_INC, CU_STEP} t_curop;
    typedef enum logic [1:0] {SO_HOLD, SO_WP, SO_CUR, SO_N} t_startop;
    typedef enum logic [1:0] {SS_HOLD, SS_FULL, SS_RANGE} t_statop;

    typedef struct packed {
        t_seq     seq;
        t_cond    cond;
        logic     neg;
        t_upc     target;
        t_rsel    rd;
        t_wsel    wr;
        t_wpop    wp_op;
        t_curop   cur_op;
        t_startop start_op;
        t_statop  st_op;
        logic     link_ld;
        logic     bl_sub;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   accept;
        logic   out_load;
    } t_seq_ctl;

    typedef struct packed {
        logic clr_done;
        logic cl_range;
        logic cl_find;
        logic rd_zero;
        logic rd_stop;
        logic rd_range;
        logic cur_end;
        logic len_lt;
        logic out_free;
    } t_flags;

    // microprogram addresses
    localparam t_upc UA_CLR     = 5'd0;
    localparam t_upc UA_IDLE    = 5'd1;
    localparam t_upc UA_RD0     = 5'd2;
    localparam t_upc UA_RD1     = 5'd3;
    localparam t_upc UA_LD0     = 5'd4;
    localparam t_upc UA_LD1     = 5'd5;
    localparam t_upc UA_FR0     = 5'd6;
    localparam t_upc UA_FR1     = 5'd7;
    localparam t_upc UA_FR2     = 5'd8;
    localparam t_upc UA_FR3     = 5'd9;
    localparam t_upc UA_FR4     = 5'd10;
    localparam t_upc UA_RANGE   = 5'd11;
    localparam t_upc UA_AL0     = 5'd12;
    localparam t_upc UA_AL1     = 5'd13;
    localparam t_upc UA_AL2     = 5'd14;
    localparam t_upc UA_LOOP    = 5'd15;
    localparam t_upc UA_MARK    = 5'd16;
    localparam t_upc UA_N0      = 5'd17;
    localparam t_upc UA_N1      = 5'd18;
    localparam t_upc UA_N2      = 5'd19;
    localparam t_upc UA_AEND    = 5'd20;
    localparam t_upc UA_AS0     = 5'd21;
    localparam t_upc UA_AS1     = 5'd22;
    localparam t_upc UA_AS2     = 5'd23;
    localparam t_upc UA_FULL    = 5'd24;
    localparam t_upc UA_RANGE_A = 5'd25;
    localparam t_upc UA_DONE    = 5'd26;

    localparam t_uword UW_NOP = '{
        seq: SQ_NEXT, cond: CD_ALWAYS, neg: 1'b0, target: UA_IDLE,
        rd: RS_NONE, wr: WS_NONE, wp_op: WP_HOLD, cur_op: CU_HOLD,
        start_op: SO_HOLD, st_op: SS_HOLD, link_ld: 1'b0, bl_sub: 1'b0
    };

    function automatic t_uword uw_jmp(input t_cond c, input logic ng, input t_upc t);
        t_uword w;
        w        = UW_NOP;
        w.seq    = SQ_JUMP;
        w.cond   = c;
        w.neg    = ng;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword ucode_rom(input t_upc a);
        t_uword w;
        w = UW_NOP;
        unique case (a)
            UA_CLR: begin
                w        = uw_jmp(CD_CLR_DONE, 1'b1, UA_CLR);
                w.wr     = WS_CLR;
                w.cur_op = CU_INC;
            end
            UA_IDLE: w.seq = SQ_WAIT;
            UA_RD0: begin
                w    = uw_jmp(CD_CL_RANGE, 1'b0, UA_RANGE);
                w.rd = RS_WP;
            end
            UA_RD1: begin
                w         = uw_jmp(CD_ALWAYS, 1'b0, UA_DONE);
                w.link_ld = 1'b1;
            end
            UA_LD0: w = uw_jmp(CD_CL_RANGE, 1'b0, UA_RANGE);
            UA_LD1: begin
                w    = uw_jmp(CD_ALWAYS, 1'b0, UA_DONE);
                w.wr = WS_VAL;
            end
            UA_FR0: w = uw_jmp(CD_CL_FIND, 1'b0, UA_DONE);
            UA_FR1: w = uw_jmp(CD_CL_RANGE, 1'b0, UA_RANGE);
            UA_FR2: w.rd = RS_WP;
            UA_FR3: begin
                w    = uw_jmp(CD_RD_STOP, 1'b0, UA_DONE);
                w.wr = WS_ZERO;
            end
            // link in range: follow it, else fall into the range report
            UA_FR4: begin
                w       = uw_jmp(CD_RD_RANGE, 1'b1, UA_FR2);
                w.wp_op = WP_RD;
            end
            UA_RANGE: begin
                w       = uw_jmp(CD_ALWAYS, 1'b0, UA_DONE);
                w.st_op = SS_RANGE;
            end
            UA_AL0: w = uw_jmp(CD_CL_FIND, 1'b0, UA_AS0);
            UA_AL1: w = uw_jmp(CD_CL_RANGE, 1'b0, UA_RANGE_A);
            UA_AL2: w.start_op = SO_WP;
            UA_LOOP: w = uw_jmp(CD_LEN_LT, 1'b0, UA_AEND);
            UA_MARK: begin
                w.wr     = WS_PART;
                w.bl_sub = 1'b1;
            end
            UA_N0: begin
                w    = uw_jmp(CD_CUR_END, 1'b0, UA_FULL);
                w.rd = RS_CUR;
            end
            UA_N1: begin
                w        = uw_jmp(CD_RD_ZERO, 1'b1, UA_N0);
                w.cur_op = CU_STEP;
            end
            UA_N2: begin
                w        = uw_jmp(CD_ALWAYS, 1'b0, UA_LOOP);
                w.wr     = WS_CUR;
                w.wp_op  = WP_CUR;
                w.cur_op = CU_INC;
            end
            UA_AEND: begin
                w    = uw_jmp(CD_ALWAYS, 1'b0, UA_DONE);
                w.wr = WS_END;
            end
            UA_AS0: begin
                w    = uw_jmp(CD_CUR_END, 1'b0, UA_FULL);
                w.rd = RS_CUR;
            end
            UA_AS1: begin
                w        = uw_jmp(CD_RD_ZERO, 1'b1, UA_AS0);
                w.cur_op = CU_STEP;
            end
            UA_AS2: begin
                w          = uw_jmp(CD_ALWAYS, 1'b0, UA_LOOP);
                w.wp_op    = WP_CUR;
                w.start_op = SO_CUR;
                w.cur_op   = CU_INC;
            end
            UA_FULL: begin
                w          = uw_jmp(CD_ALWAYS, 1'b0, UA_DONE);
                w.st_op    = SS_FULL;
                w.start_op = SO_N;
            end
            UA_RANGE_A: begin
                w          = uw_jmp(CD_ALWAYS, 1'b0, UA_DONE);
                w.st_op    = SS_RANGE;
                w.start_op = SO_N;
            end
            UA_DONE: w.seq = SQ_DONE;
            default: w = uw_jmp(CD_ALWAYS, 1'b0, UA_IDLE);
        endcase
        return w;
    endfunction

    function automatic t_upc op_entry(input logic [OP_W-1:0] op);
        t_upc a;
        unique case (op)
            OP_READ:  a = UA_RD0;
            OP_ALLOC: a = UA_AL0;
            OP_FREE:  a = UA_FR0;
            OP_LOAD:  a = UA_LD0;
            default:  a = UA_IDLE;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/cct_ifs.sv @@
// Cluster chain table: request and result channel interfaces.
interface cct_req_if import cct_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [CL_W-1:0]  cluster;
    logic [LEN_W-1:0] length;
    logic [EV_W-1:0]  entry_value;

    modport source (output valid, output op, output cluster, output length,
                    output entry_value, input ready);
    modport sink (input valid, input op, input cluster, input length,
                  input entry_value, output ready);
endinterface

interface cct_rsp_if import cct_pkg::*;;
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [CL_W-1:0] start_cluster;
    logic [EV_W-1:0] link_value;

    modport source (output valid, output status, output start_cluster,
                    output link_value, input ready);
    modport sink (input valid, input status, input start_cluster,
                  input link_value, output ready);
endinterface

@@ rtl/core/cct_cfg.sv @@
// Cluster chain table: APB configuration registers and effective count/size.
module cct_cfg import cct_pkg::*; #(
    parameter int MAX_CLUSTERS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [CFG_AW-1:0]                    paddr,
    input  logic [CFG_DW-1:0]                    pwdata,
    output logic [CFG_DW-1:0]                    prdata,
    output logic                                 pready,
    output logic [$clog2(MAX_CLUSTERS+1)-1:0]    o_active_count,
    output logic [CS_W-1:0]                      o_cluster_size
);
    localparam int CW = $clog2(MAX_CLUSTERS + 1);

    logic [CC_W-1:0] r_cluster_count, n_cluster_count;
    logic [CS_W-1:0] r_cluster_size, n_cluster_size;
    t_reg_idx        reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cluster_count = r_cluster_count;
        n_cluster_size  = r_cluster_size;
        if (wr_en) begin
            unique case (reg_idx)
                REG_CLUSTER_COUNT: n_cluster_count = pwdata[CC_W-1:0];
                REG_CLUSTER_SIZE:  n_cluster_size  = pwdata[CS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CLUSTER_COUNT_RST;
            r_cluster_size  <= CLUSTER_SIZE_RST;
        end else begin
            r_cluster_count <= n_cluster_count;
            r_cluster_size  <= n_cluster_size;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CLUSTER_COUNT: prdata = CFG_DW'(r_cluster_count);
            REG_CLUSTER_SIZE:  prdata = CFG_DW'(r_cluster_size);
            default:           prdata = '0;
        endcase
    end

    // count saturates at table depth, zero size behaves as one byte
    always_comb begin
        if (32'(r_cluster_count) > MAX_CLUSTERS) begin
            o_active_count = CW'(MAX_CLUSTERS);
        end else begin
            o_active_count = CW'(r_cluster_count);
        end
        o_cluster_size = (r_cluster_size == '0) ? CS_W'(1) : r_cluster_size;
    end

endmodule

@@ rtl/core/cct_useq.sv @@
// Cluster chain table: microprogram sequencer (step counter, jumps, dispatch).
module cct_useq import cct_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_flags          i_flags,
    input  logic            i_req_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_req_ready,
    output t_seq_ctl        o_ctl
);
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   hit;
    logic   out_load;

    assign uw = ucode_rom(r_upc);

    always_comb begin
        unique case (uw.cond)
            CD_ALWAYS:   hit = 1'b1;
            CD_CLR_DONE: hit = i_flags.clr_done;
            CD_CL_RANGE: hit = i_flags.cl_range;
            CD_CL_FIND:  hit = i_flags.cl_find;
            CD_RD_ZERO:  hit = i_flags.rd_zero;
            CD_RD_STOP:  hit = i_flags.rd_stop;
            CD_RD_RANGE: hit = i_flags.rd_range;
            CD_CUR_END:  hit = i_flags.cur_end;
            CD_LEN_LT:   hit = i_flags.len_lt;
            default:     hit = 1'b0;
        endcase
    end

    always_comb begin
        n_upc       = r_upc;
        o_req_ready = 1'b0;
        out_load    = 1'b0;
        unique case (uw.seq)
            SQ_NEXT: n_upc = r_upc + t_upc'(1);
            SQ_JUMP: n_upc = (hit ^ uw.neg) ? uw.target : r_upc + t_upc'(1);
            SQ_WAIT: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_upc = op_entry(i_op);
                end
            end
            SQ_DONE: begin
                if (i_flags.out_free) begin
                    out_load = 1'b1;
                    n_upc    = UA_IDLE;
                end
            end
            default: n_upc = UA_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl = '{uw: uw, accept: o_req_ready && i_req_valid, out_load: out_load};

endmodule

@@ rtl/core/cct_dpath.sv @@
// Cluster chain table: link memory, walk/scan registers and result register.
module cct_dpath import cct_pkg::*; #(
    parameter int MAX_CLUSTERS = 1024,
    parameter int LINK_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_seq_ctl                          i_ctl,
    input  logic [CL_W-1:0]                   i_cluster,
    input  logic [LEN_W-1:0]                  i_length,
    input  logic [EV_W-1:0]                   i_entry_value,
    input  logic [$clog2(MAX_CLUSTERS+1)-1:0] i_active_count,
    input  logic [CS_W-1:0]                   i_cluster_size,
    input  logic                              i_out_ready,
    output t_flags                            o_flags,
    output logic                              o_out_valid,
    output logic [ST_W-1:0]                   o_status,
    output logic [CL_W-1:0]                   o_start_cluster,
    output logic [EV_W-1:0]                   o_link_value
);
    localparam int AW = $clog2(MAX_CLUSTERS);
    localparam int CW = $clog2(MAX_CLUSTERS + 1);

    t_uword uw;

    logic [LINK_BITS-1:0] r_mem [MAX_CLUSTERS];
    logic [LINK_BITS-1:0] r_rd;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_wa;
    logic [AW-1:0]        mem_ra;
    logic [LINK_BITS-1:0] mem_wd;

    logic [CL_W-1:0]      r_cl, n_cl;
    logic [LINK_BITS-1:0] r_val, n_val;
    logic [LEN_W-1:0]     r_bl, n_bl;
    logic [AW-1:0]        r_wp, n_wp;
    logic [CW-1:0]        r_cur, n_cur;
    logic [ST_W-1:0]      r_status, n_status;
    logic [CL_W-1:0]      r_start, n_start;
    logic [EV_W-1:0]      r_link, n_link;

    logic                 r_ovalid, n_ovalid;
    logic [ST_W-1:0]      r_ostatus, n_ostatus;
    logic [CL_W-1:0]      r_ostart, n_ostart;
    logic [EV_W-1:0]      r_olink, n_olink;

    assign uw = i_ctl.uw;

    // flags for the sequencer
    always_comb begin
        o_flags.clr_done = (r_cur == CW'(MAX_CLUSTERS - 1));
        o_flags.cl_range = (32'(r_cl) >= 32'(i_active_count));
        o_flags.cl_find  = (r_cl == FIND_FREE);
        o_flags.rd_zero  = (r_rd == '0);
        o_flags.rd_stop  = (r_rd == '0) || (r_rd == '1);
        o_flags.rd_range = (33'(r_rd) >= 33'(i_active_count));
        o_flags.cur_end  = (r_cur >= i_active_count);
        o_flags.len_lt   = (r_bl < LEN_W'(i_cluster_size));
        o_flags.out_free = !r_ovalid || i_out_ready;
    end

    // memory port control
    always_comb begin
        mem_we = 1'b1;
        mem_wa = r_wp;
        mem_wd = '0;
        case (uw.wr)
            WS_NONE: mem_we = 1'b0;
            WS_CLR:  mem_wa = AW'(r_cur);
            WS_ZERO: mem_wd = '0;
            WS_VAL:  mem_wd = r_val;
            WS_PART: mem_wd = LINK_BITS'(PARTIAL_MARK);
            WS_END:  mem_wd = '1;
            WS_CUR:  mem_wd = LINK_BITS'(r_cur);
            default: mem_we = 1'b0;
        endcase
        mem_re = (uw.rd != RS_NONE);
        mem_ra = (uw.rd == RS_CUR) ? AW'(r_cur) : r_wp;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    // working registers
    always_comb begin
        n_cl     = r_cl;
        n_val    = r_val;
        n_bl     = r_bl;
        n_wp     = r_wp;
        n_cur    = r_cur;
        n_status = r_status;
        n_start  = r_start;
        n_link   = r_link;
        if (i_ctl.accept) begin
            n_cl     = i_cluster;
            n_val    = LINK_BITS'(i_entry_value);
            n_bl     = i_length;
            n_wp     = AW'(i_cluster);
            n_cur    = CW'(1);
            n_status = ST_OK;
            n_start  = '0;
            n_link   = '0;
        end else begin
            case (uw.wp_op)
                WP_RD:   n_wp = AW'(r_rd);
                WP_CUR:  n_wp = AW'(r_cur);
                default: ;
            endcase
            case (uw.cur_op)
                CU_INC:  n_cur = r_cur + CW'(1);
                CU_STEP: n_cur = (r_rd != '0) ? r_cur + CW'(1) : r_cur;
                default: ;
            endcase
            case (uw.start_op)
                SO_WP:   n_start = CL_W'(r_wp);
                SO_CUR:  n_start = CL_W'(r_cur);
                SO_N:    n_start = CL_W'(i_active_count);
                default: ;
            endcase
            case (uw.st_op)
                SS_FULL:  n_status = ST_FULL;
                SS_RANGE: n_status = ST_RANGE;
                default:  ;
            endcase
            if (uw.link_ld) begin
                n_link = EV_W'(r_rd);
            end
            if (uw.bl_sub) begin
                n_bl = r_bl - LEN_W'(i_cluster_size);
            end
        end
    end

    // result register, freed when taken
    always_comb begin
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ostart  = r_ostart;
        n_olink   = r_olink;
        if (i_ctl.out_load) begin
            n_ovalid  = 1'b1;
            n_ostatus = r_status;
            n_ostart  = r_start;
            n_olink   = r_link;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cur    <= n_cur;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cl      <= n_cl;
        r_val     <= n_val;
        r_bl      <= n_bl;
        r_wp      <= n_wp;
        r_status  <= n_status;
        r_start   <= n_start;
        r_link    <= n_link;
        r_ostatus <= n_ostatus;
        r_ostart  <= n_ostart;
        r_olink   <= n_olink;
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_start_cluster = r_ostart;
    assign o_link_value    = r_olink;

endmodule

@@ rtl/core/cluster_chain_table_unit.sv @@
// Cluster chain table: top level.
//
// Requests arrive on i_req (op, cluster, length, entry_value) and each gives
// exactly one result on o_rsp (status, start_cluster, link_value); both are
// valid/ready channels. Configuration (cluster_count at 0x0, cluster_size at
// 0x4) is to be written over the APB port while the block is idle; the
// block itself does not enforce this. One request is worked at a time by a
// microprogram over a link memory with separate write and read addresses and
// a registered read. Free follows the chain link by link; allocate takes the
// given start cluster or searches one, then searches a free entry for each
// further cluster; the free-cluster scan never revisits an entry.
// The next request is taken in the cycle after the result is loaded, even if
// the receiver has not yet taken it; a second result waits in the
// sequencer until the output register frees.
// After reset the whole link memory is cleared one entry a cycle, with
// i_req.ready low; configuration writes are accepted meanwhile.
module cluster_chain_table_unit import cct_pkg::*; #(
    parameter int MAX_CLUSTERS = 1024,
    parameter int LINK_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cct_req_if.sink           i_req,
    cct_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);
    localparam int CW = $clog2(MAX_CLUSTERS + 1);

    logic [CW-1:0]   active_count;
    logic [CS_W-1:0] cluster_size;
    t_flags          flags;
    t_seq_ctl        ctl;
    logic            req_ready;

    cct_cfg #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_active_count (active_count),
        .o_cluster_size (cluster_size)
    );

    cct_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flags     (flags),
        .i_req_valid (i_req.valid),
        .i_op        (i_req.op),
        .o_req_ready (req_ready),
        .o_ctl       (ctl)
    );

    cct_dpath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .LINK_BITS    (LINK_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_cluster       (i_req.cluster),
        .i_length        (i_req.length),
        .i_entry_value   (i_req.entry_value),
        .i_active_count  (active_count),
        .i_cluster_size  (cluster_size),
        .i_out_ready     (o_rsp.ready),
        .o_flags         (flags),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_start_cluster (o_rsp.start_cluster),
        .o_link_value    (o_rsp.link_value)
    );

    assign i_req.ready = req_ready;

endmodule
